// ----- design/vpn_pkg.sv -----
// Package for the patchify and normalize block: widths, constants, register indexes, types.
`timescale 1ns / 1ps
`default_nettype none

package vpn_pkg;

  // Geometry
  localparam int PATCH           = 14;
  localparam int MERGE           = 2;
  localparam int TEMPORAL_COPIES = 2;
  localparam int MAX_SIDE        = 4096;
  localparam int NUM_CH          = 3;

  // Field widths
  localparam int SIDE_W    = 12;
  localparam int CH_W      = 2;
  localparam int RAW_W     = 8;
  localparam int PROW_W    = 17;
  localparam int FCOL_W    = 11;
  localparam int FIX_W     = 27;
  localparam int BF_W      = 16;
  localparam int GW_W      = 9;
  localparam int OFS_W     = 16;
  localparam int GAIN_W    = 24;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 4;

  localparam logic [CH_W-1:0] CH_BLUE = CH_W'(2);

  // Coordinates saturate here
  localparam int SIDE_MAX = (MAX_SIDE < 2**SIDE_W) ? MAX_SIDE - 1 : 2**SIDE_W - 1;
  localparam int GRID_W   = $clog2(SIDE_MAX / PATCH + 1);
  localparam int PH_W     = (PATCH > 1) ? $clog2(PATCH) : 1;

  // Divide by PATCH as a multiply by a rounded-up reciprocal
  localparam int DIVP_SH  = SIDE_W + $clog2(PATCH);
  localparam int DIVP_PW  = SIDE_W + DIVP_SH + 1;
  localparam longint RECIP_P = (longint'(2)**DIVP_SH + PATCH - 1) / PATCH;

  // Divide by MERGE the same way
  localparam int DM_W     = (GRID_W > GW_W) ? GRID_W : GW_W;
  localparam int DIVM_SH  = DM_W + $clog2(MERGE);
  localparam int DIVM_PW  = DM_W + DIVM_SH + 1;
  localparam longint RECIP_M = (longint'(2)**DIVM_SH + MERGE - 1) / MERGE;
  localparam int MG_W     = (MERGE > 1) ? $clog2(MERGE) : 1;

  // Normalize arithmetic
  localparam int OFS_FRAC  = 8;
  localparam int D_W       = RAW_W + OFS_FRAC + 1;
  localparam int PROD_W    = D_W + GAIN_W + 1;
  localparam int RND_SH    = 14;
  localparam int RND_W     = PROD_W - RND_SH;
  localparam int FIX_FRAC  = 16;
  localparam longint FIX_MAX     = longint'(2)**(FIX_W-1) - 1;
  localparam longint FIX_NEG_MAG = longint'(2)**(FIX_W-1);
  localparam int MSB_W     = $clog2(FIX_W);
  localparam int BF_BIAS   = 127 - FIX_FRAC;
  localparam int BF_MANT_W = 7;
  localparam int BF_EXP_W  = 8;

  localparam int CNT_W = (TEMPORAL_COPIES > 1) ? $clog2(TEMPORAL_COPIES) : 1;

  // Register reset values
  localparam logic [GW_W-1:0]   GRID_WIDTH_RST = GW_W'(16);
  localparam logic [OFS_W-1:0]  OFFSET_RST     = OFS_W'(32640);
  localparam logic [GAIN_W-1:0] GAIN_RST       = GAIN_W'(32896);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SHUFFLE_MODE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_RED   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_GREEN = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BLUE  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_RED     = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_GREEN   = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_BLUE    = CFG_IDX_W'(7);

  // Index fields carried down the back half of the pipe
  typedef struct packed {
    logic [PROW_W-1:0] prow;
    logic [FCOL_W-1:0] fbase;
  } idx_t;

endpackage

`default_nettype wire

// ----- design/vit_patchify_normalize.sv -----
// Patchify and normalize: patch indices plus Q10.16 and bfloat16 normalized value per byte.
// Each accepted item passes through stages 1 to 8 and then the output register, in order.
// The output register sends each item's TEMPORAL_COPIES copies one per cycle unless out_stall_i
// holds it, while the eight stages behind it hold; no new item enters until the last copy goes.
// Reset: clears all stage valid bits and the copy counter; config registers go to reset values.
`timescale 1ns / 1ps
`default_nettype none

module vit_patchify_normalize (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration
  input  wire logic                           cfg_we_i,
  input  wire logic [vpn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [vpn_pkg::CFG_W-1:0]      cfg_data_i,
  // input items
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [vpn_pkg::SIDE_W-1:0]     pixel_row_i,
  input  wire logic [vpn_pkg::SIDE_W-1:0]     pixel_col_i,
  input  wire logic [vpn_pkg::CH_W-1:0]       channel_i,
  input  wire logic [vpn_pkg::RAW_W-1:0]      raw_i,
  // result items
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [vpn_pkg::PROW_W-1:0]          patch_row_o,
  output logic [vpn_pkg::FCOL_W-1:0]          feature_col_o,
  output logic signed [vpn_pkg::FIX_W-1:0]    value_fixed_o,
  output logic [vpn_pkg::BF_W-1:0]            value_bf16_o,
  output logic                                last_o
);

  import vpn_pkg::*;

  // ---------------- configuration registers ----------------
  logic [GW_W-1:0]   grid_w_q;
  logic              shuffle_q;
  logic [OFS_W-1:0]  offset_q [NUM_CH];
  logic [GAIN_W-1:0] gain_q   [NUM_CH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q  <= GRID_WIDTH_RST;
      shuffle_q <= 1'b0;
      for (int c = 0; c < NUM_CH; c++) begin
        offset_q[c] <= OFFSET_RST;
        gain_q[c]   <= GAIN_RST;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRID_WIDTH:   grid_w_q    <= cfg_data_i[GW_W-1:0];
        REG_SHUFFLE_MODE: shuffle_q   <= cfg_data_i[0];
        REG_OFFSET_RED:   offset_q[0] <= cfg_data_i[OFS_W-1:0];
        REG_OFFSET_GREEN: offset_q[1] <= cfg_data_i[OFS_W-1:0];
        REG_OFFSET_BLUE:  offset_q[2] <= cfg_data_i[OFS_W-1:0];
        REG_GAIN_RED:     gain_q[0]   <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_GREEN:   gain_q[1]   <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_BLUE:    gain_q[2]   <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic adv;
  logic out_last;
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q, s7_v_q, s8_v_q;
  logic o_v_q;
  logic [CNT_W-1:0] o_cnt_q;

  assign out_last   = (o_cnt_q == CNT_W'(TEMPORAL_COPIES - 1));
  // whole pipe moves when the output register can take a new item
  assign adv        = !o_v_q || (!out_stall_i && out_last);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      s6_v_q  <= 1'b0;
      s7_v_q  <= 1'b0;
      s8_v_q  <= 1'b0;
      o_v_q   <= 1'b0;
      o_cnt_q <= '0;
    end else if (adv) begin
      s1_v_q  <= in_valid_i;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
      s5_v_q  <= s4_v_q;
      s6_v_q  <= s5_v_q;
      s7_v_q  <= s6_v_q;
      s8_v_q  <= s7_v_q;
      o_v_q   <= s8_v_q;
      o_cnt_q <= '0;
    end else if (!out_stall_i) begin
      o_cnt_q <= o_cnt_q + CNT_W'(1);
    end
  end

  // ---------------- stage 1: capture and clamp ----------------
  logic [SIDE_W-1:0] s1_row_q, s1_col_q;
  logic [CH_W-1:0]   s1_ch_q;
  logic [RAW_W-1:0]  s1_raw_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_row_q <= (32'(pixel_row_i) > SIDE_MAX) ? SIDE_W'(SIDE_MAX) : pixel_row_i;
      s1_col_q <= (32'(pixel_col_i) > SIDE_MAX) ? SIDE_W'(SIDE_MAX) : pixel_col_i;
      s1_ch_q  <= (channel_i > CH_BLUE) ? CH_BLUE : channel_i;  // channel three reads as blue
      s1_raw_q <= raw_i;
    end
  end

  // ---------------- stage 2: grid coords, offset subtract ----------------
  logic [DIVP_PW-1:0]     gy_prod, gx_prod;
  logic [GRID_W-1:0]      s2_gy_q, s2_gx_q;
  logic [SIDE_W-1:0]      s2_row_q, s2_col_q;
  logic [CH_W-1:0]        s2_ch_q;
  logic signed [D_W-1:0]  s2_d_q;
  logic [GAIN_W-1:0]      s2_gain_q;

  assign gy_prod = DIVP_PW'(s1_row_q) * DIVP_PW'(RECIP_P);
  assign gx_prod = DIVP_PW'(s1_col_q) * DIVP_PW'(RECIP_P);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_gy_q   <= GRID_W'(gy_prod >> DIVP_SH);
      s2_gx_q   <= GRID_W'(gx_prod >> DIVP_SH);
      s2_row_q  <= s1_row_q;
      s2_col_q  <= s1_col_q;
      s2_ch_q   <= s1_ch_q;
      s2_d_q    <= $signed({1'b0, s1_raw_q, OFS_FRAC'(0)})
                 - $signed({1'b0, offset_q[s1_ch_q]});
      s2_gain_q <= gain_q[s1_ch_q];
    end
  end

  // ---------------- stage 3: in-patch offsets, gain multiply, merge split ----------------
  logic [DIVM_PW-1:0]       by_prod, bx_prod, bw_prod;
  logic [PH_W-1:0]          s3_ph_q, s3_pw_q;
  logic [GRID_W-1:0]        s3_gy_q, s3_gx_q;
  logic [DM_W-1:0]          s3_by_q, s3_bx_q, s3_bw_q;
  logic [CH_W-1:0]          s3_ch_q;
  logic signed [PROD_W-1:0] s3_prod_q;

  assign by_prod = DIVM_PW'(s2_gy_q) * DIVM_PW'(RECIP_M);
  assign bx_prod = DIVM_PW'(s2_gx_q) * DIVM_PW'(RECIP_M);
  assign bw_prod = DIVM_PW'(grid_w_q) * DIVM_PW'(RECIP_M);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_ph_q   <= PH_W'(s2_row_q - SIDE_W'(s2_gy_q) * SIDE_W'(PATCH));
      s3_pw_q   <= PH_W'(s2_col_q - SIDE_W'(s2_gx_q) * SIDE_W'(PATCH));
      s3_gy_q   <= s2_gy_q;
      s3_gx_q   <= s2_gx_q;
      s3_by_q   <= DM_W'(by_prod >> DIVM_SH);
      s3_bx_q   <= DM_W'(bx_prod >> DIVM_SH);
      s3_bw_q   <= DM_W'(bw_prod >> DIVM_SH);
      s3_ch_q   <= s2_ch_q;
      s3_prod_q <= PROD_W'(s2_d_q * $signed({1'b0, s2_gain_q}));
    end
  end

  // ---------------- stage 4: round magnitude, row products, feature base ----------------
  logic                   prod_neg;
  logic [PROD_W-1:0]      prod_abs;
  logic                   s4_neg_q;
  logic [RND_W-1:0]       s4_rnd_q;
  logic [PROW_W-1:0]      s4_rm_q, s4_blk_q;
  logic [MG_W-1:0]        s4_my_q, s4_mx_q;
  logic [FCOL_W-1:0]      s4_fbase_q;

  assign prod_neg = s3_prod_q[PROD_W-1];
  assign prod_abs = prod_neg ? PROD_W'(-s3_prod_q) : PROD_W'(s3_prod_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_neg_q   <= prod_neg;
      // ties away from zero: round the magnitude
      s4_rnd_q   <= RND_W'((prod_abs + PROD_W'(2**(RND_SH-1))) >> RND_SH);
      s4_rm_q    <= PROW_W'(PROW_W'(s3_gy_q) * PROW_W'(grid_w_q) + PROW_W'(s3_gx_q));
      s4_blk_q   <= PROW_W'(PROW_W'(s3_by_q) * PROW_W'(s3_bw_q) + PROW_W'(s3_bx_q));
      s4_my_q    <= MG_W'(DM_W'(s3_gy_q) - s3_by_q * DM_W'(MERGE));
      s4_mx_q    <= MG_W'(DM_W'(s3_gx_q) - s3_bx_q * DM_W'(MERGE));
      s4_fbase_q <= FCOL_W'(s3_ch_q) * FCOL_W'(TEMPORAL_COPIES * PATCH * PATCH)
                  + FCOL_W'(s3_ph_q) * FCOL_W'(PATCH) + FCOL_W'(s3_pw_q);
    end
  end

  // ---------------- stage 5: saturate, final patch row ----------------
  logic             s5_neg_q;
  logic [FIX_W-1:0] s5_mag_q;
  idx_t             s5_idx_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_neg_q <= s4_neg_q;
      if (s4_neg_q) begin
        s5_mag_q <= (RND_W'(s4_rnd_q) > RND_W'(FIX_NEG_MAG)) ? FIX_W'(FIX_NEG_MAG)
                                                            : FIX_W'(s4_rnd_q);
      end else begin
        s5_mag_q <= (RND_W'(s4_rnd_q) > RND_W'(FIX_MAX)) ? FIX_W'(FIX_MAX)
                                                         : FIX_W'(s4_rnd_q);
      end
      s5_idx_q.prow  <= shuffle_q
          ? PROW_W'((s4_blk_q * PROW_W'(MERGE) + PROW_W'(s4_my_q)) * PROW_W'(MERGE)
                    + PROW_W'(s4_mx_q))
          : s4_rm_q;
      s5_idx_q.fbase <= s4_fbase_q;
    end
  end

  // ---------------- stage 6: signed value, leading one ----------------
  logic [MSB_W-1:0]        msb_d;
  logic                    s6_neg_q;
  logic [FIX_W-1:0]        s6_mag_q;
  logic [MSB_W-1:0]        s6_msb_q;
  logic signed [FIX_W-1:0] s6_fix_q;
  idx_t                    s6_idx_q;

  always_comb begin
    msb_d = '0;
    for (int i = 0; i < FIX_W; i++) begin
      if (s5_mag_q[i]) msb_d = MSB_W'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_neg_q <= s5_neg_q;
      s6_mag_q <= s5_mag_q;
      s6_msb_q <= msb_d;
      s6_fix_q <= s5_neg_q ? $signed(FIX_W'(-s5_mag_q)) : $signed(s5_mag_q);
      s6_idx_q <= s5_idx_q;
    end
  end

  // ---------------- stage 7: normalize ----------------
  logic                    s7_neg_q, s7_zero_q;
  logic [FIX_W-1:0]        s7_norm_q;
  logic [MSB_W-1:0]        s7_msb_q;
  logic signed [FIX_W-1:0] s7_fix_q;
  idx_t                    s7_idx_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_neg_q  <= s6_neg_q;
      s7_zero_q <= (s6_mag_q == '0);
      s7_norm_q <= s6_mag_q << (MSB_W'(FIX_W - 1) - s6_msb_q);
      s7_msb_q  <= s6_msb_q;
      s7_fix_q  <= s6_fix_q;
      s7_idx_q  <= s6_idx_q;
    end
  end

  // ---------------- stage 8: bfloat16 round to nearest even ----------------
  localparam int MANT_LO = FIX_W - 1 - BF_MANT_W;

  logic [BF_MANT_W:0]      mant8;
  logic                    round_up;
  logic [BF_MANT_W+1:0]    mant9;
  logic [BF_EXP_W-1:0]     bf_exp;
  logic [BF_W-1:0]         bf_d;
  logic [BF_W-1:0]         s8_bf_q;
  logic signed [FIX_W-1:0] s8_fix_q;
  idx_t                    s8_idx_q;

  assign mant8    = s7_norm_q[FIX_W-1:MANT_LO];
  assign round_up = s7_norm_q[MANT_LO-1]
                  & ((|s7_norm_q[MANT_LO-2:0]) | s7_norm_q[MANT_LO]);
  assign mant9    = {1'b0, mant8} + (BF_MANT_W+2)'(round_up);
  // mantissa carry out bumps the exponent; low bits are then zero
  assign bf_exp   = BF_EXP_W'(s7_msb_q) + BF_EXP_W'(BF_BIAS) + BF_EXP_W'(mant9[BF_MANT_W+1]);
  assign bf_d     = s7_zero_q ? '0 : {s7_neg_q, bf_exp, mant9[BF_MANT_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s8_bf_q  <= bf_d;
      s8_fix_q <= s7_fix_q;
      s8_idx_q <= s7_idx_q;
    end
  end

  // ---------------- output register: one copy per temporal slot ----------------
  logic [PROW_W-1:0]       o_prow_q;
  logic [FCOL_W-1:0]       o_fcol_q;
  logic signed [FIX_W-1:0] o_fix_q;
  logic [BF_W-1:0]         o_bf_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_prow_q <= s8_idx_q.prow;
      o_fcol_q <= s8_idx_q.fbase;
      o_fix_q  <= s8_fix_q;
      o_bf_q   <= s8_bf_q;
    end else if (!out_stall_i) begin
      o_fcol_q <= o_fcol_q + FCOL_W'(PATCH * PATCH);
    end
  end

  assign out_valid_o   = o_v_q;
  assign patch_row_o   = o_prow_q;
  assign feature_col_o = o_fcol_q;
  assign value_fixed_o = o_fix_q;
  assign value_bf16_o  = o_bf_q;
  assign last_o        = out_last;

endmodule

`default_nettype wire
